// ===== src/sqcp_pkg.sv =====
// ----------------------------------------------------------------------------
// sqcp_pkg
// Shared types, constants and codes of the sequential capacity partitioner.
// ----------------------------------------------------------------------------
package sqcp_pkg;

    localparam int SET_DEPTH_DEF  = 1024;
    localparam int NODE_EDGES_DEF = 64;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_NODES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_EDGES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PARTS = 2'd2;

    localparam logic [15:0] MAX_NODES_RST = 16'd256;
    localparam logic [9:0]  MAX_EDGES_RST = 10'd1023;
    localparam logic [15:0] MAX_PARTS_RST = 16'd65535;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_PART_ERR = 2'd1;
    localparam logic [1:0] STATUS_NODE_OVF = 2'd2;

    localparam logic [16:0] NODE_COUNT_MAX = 17'h1FFFF;
    localparam logic [15:0] PART_MAX       = 16'hFFFF;

    typedef struct packed {
        logic        start_graph;
        logic        edge_valid;
        logic [31:0] edge_id;
        logic        node_last;
    } t_in_item;

    typedef struct packed {
        logic [15:0] part_index;
        logic [1:0]  status;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_CMP,
        S_FINISH,
        S_REPLAY,
        S_RLOAD,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic accept;
        logic scan_start;
        logic scan_rd;
        logic scan_next;
        logic insert;
        logic finish;
        logic replay_start;
        logic replay_rd;
        logic replay_load;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic in_edge;
        logic in_last;
        logic item_last;
        logic scan_end;
        logic match;
        logic restart;
        logic replay_end;
        logic out_free;
    } t_stat;

endpackage

// ===== src/sqcp_ram.sv =====
// ----------------------------------------------------------------------------
// sqcp_ram
// Simple dual-port RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module sqcp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/sqcp_ctrl.sv =====
// ----------------------------------------------------------------------------
// sqcp_ctrl
// Controller state machine that sequences set lookups, node ends and replays.
// ----------------------------------------------------------------------------
module sqcp_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  sqcp_pkg::t_stat i_stat,
    output sqcp_pkg::t_cmd  o_cmd
);

    sqcp_pkg::t_state r_state, n_state;
    logic             r_replay, n_replay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= sqcp_pkg::S_IDLE;
            r_replay <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_replay <= n_replay;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_replay   = r_replay;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            sqcp_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                n_replay   = 1'b0;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_stat.in_edge) begin
                        o_cmd.scan_start = 1'b1;
                        n_state          = sqcp_pkg::S_SCAN;
                    end else if (i_stat.in_last) begin
                        n_state = sqcp_pkg::S_FINISH;
                    end
                end
            end
            sqcp_pkg::S_SCAN: begin
                if (i_stat.scan_end) begin
                    o_cmd.insert = 1'b1;
                    if (r_replay) begin
                        n_state = sqcp_pkg::S_REPLAY;
                    end else if (i_stat.item_last) begin
                        n_state = sqcp_pkg::S_FINISH;
                    end else begin
                        n_state = sqcp_pkg::S_IDLE;
                    end
                end else begin
                    o_cmd.scan_rd = 1'b1;
                    n_state       = sqcp_pkg::S_CMP;
                end
            end
            sqcp_pkg::S_CMP: begin
                if (i_stat.match) begin
                    if (r_replay) begin
                        n_state = sqcp_pkg::S_REPLAY;
                    end else if (i_stat.item_last) begin
                        n_state = sqcp_pkg::S_FINISH;
                    end else begin
                        n_state = sqcp_pkg::S_IDLE;
                    end
                end else begin
                    o_cmd.scan_next = 1'b1;
                    n_state         = sqcp_pkg::S_SCAN;
                end
            end
            sqcp_pkg::S_FINISH: begin
                o_cmd.finish = 1'b1;
                if (i_stat.restart) begin
                    o_cmd.replay_start = 1'b1;
                    n_replay           = 1'b1;
                    n_state            = sqcp_pkg::S_REPLAY;
                end else begin
                    n_state = sqcp_pkg::S_EMIT;
                end
            end
            sqcp_pkg::S_REPLAY: begin
                if (i_stat.replay_end) begin
                    n_replay = 1'b0;
                    n_state  = sqcp_pkg::S_EMIT;
                end else begin
                    o_cmd.replay_rd = 1'b1;
                    n_state         = sqcp_pkg::S_RLOAD;
                end
            end
            sqcp_pkg::S_RLOAD: begin
                o_cmd.replay_load = 1'b1;
                o_cmd.scan_start  = 1'b1;
                n_state           = sqcp_pkg::S_SCAN;
            end
            sqcp_pkg::S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = sqcp_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = sqcp_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== src/sqcp_dp.sv =====
// ----------------------------------------------------------------------------
// sqcp_dp
// Datapath: edge set and node buffer memories, counters, limits and result.
// ----------------------------------------------------------------------------
module sqcp_dp #(
    parameter int SET_DEPTH  = sqcp_pkg::SET_DEPTH_DEF,
    parameter int NODE_EDGES = sqcp_pkg::NODE_EDGES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [sqcp_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [sqcp_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  sqcp_pkg::t_in_item                i_in,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output sqcp_pkg::t_out_item               o_out,
    input  sqcp_pkg::t_cmd                    i_cmd,
    output sqcp_pkg::t_stat                   o_stat
);

    localparam int SAW = $clog2(SET_DEPTH);
    localparam int SCW = $clog2(SET_DEPTH + 1);
    localparam int NAW = (NODE_EDGES > 1) ? $clog2(NODE_EDGES) : 1;
    localparam int NCW = $clog2(NODE_EDGES + 1);

    logic [15:0]         r_max_nodes;
    logic [9:0]          r_max_edges;
    logic [15:0]         r_max_parts;
    logic [31:0]         r_id, n_id;
    logic                r_last, n_last;
    logic [SCW-1:0]      r_dcnt, n_dcnt;
    logic                r_over, n_over;
    logic [16:0]         r_ncnt, n_ncnt;
    logic [15:0]         r_part, n_part;
    logic                r_perr, n_perr;
    logic [NCW-1:0]      r_necnt, n_necnt;
    logic                r_novf, n_novf;
    logic [SCW-1:0]      r_scan, n_scan;
    logic [NCW-1:0]      r_rep, n_rep;
    sqcp_pkg::t_out_item r_out, n_out;
    logic                r_out_valid, n_out_valid;

    logic [NCW-1:0] nec_base;
    logic           novf_base;
    logic           buf_we;
    logic           set_we;
    logic           ins_ok;
    logic [16:0]    nc_inc;
    logic [15:0]    part_inc;
    logic [31:0]    set_rdata;
    logic [31:0]    nbuf_rdata;

    assign nec_base  = i_in.start_graph ? '0 : r_necnt;
    assign novf_base = i_in.start_graph ? 1'b0 : r_novf;
    assign buf_we    = i_cmd.accept && i_in.edge_valid &&
                       (32'(nec_base) < 32'(NODE_EDGES));
    assign ins_ok    = !((32'(r_dcnt) > 32'(r_max_edges)) ||
                         (32'(r_dcnt) >= 32'(SET_DEPTH)));
    assign set_we    = i_cmd.insert && ins_ok;
    assign nc_inc    = (r_ncnt == sqcp_pkg::NODE_COUNT_MAX) ? r_ncnt : r_ncnt + 17'd1;
    assign part_inc  = (r_part == sqcp_pkg::PART_MAX) ? r_part : r_part + 16'd1;

    sqcp_ram #(.WIDTH(32), .DEPTH(SET_DEPTH), .AW(SAW)) u_set_ram (
        .i_clk   (i_clk),
        .i_we    (set_we),
        .i_waddr (r_dcnt[SAW-1:0]),
        .i_wdata (r_id),
        .i_re    (i_cmd.scan_rd),
        .i_raddr (r_scan[SAW-1:0]),
        .o_rdata (set_rdata)
    );

    sqcp_ram #(.WIDTH(32), .DEPTH(NODE_EDGES), .AW(NAW)) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (buf_we),
        .i_waddr (nec_base[NAW-1:0]),
        .i_wdata (i_in.edge_id),
        .i_re    (i_cmd.replay_rd),
        .i_raddr (r_rep[NAW-1:0]),
        .o_rdata (nbuf_rdata)
    );

    always_comb begin
        o_stat.in_edge    = i_in.edge_valid;
        o_stat.in_last    = i_in.node_last;
        o_stat.item_last  = r_last;
        o_stat.scan_end   = (r_scan == r_dcnt);
        o_stat.match      = (set_rdata == r_id);
        o_stat.restart    = (nc_inc > {1'b0, r_max_nodes}) || r_over ||
                            (32'(r_dcnt) > 32'(r_max_edges));
        o_stat.replay_end = (r_rep == r_necnt);
        o_stat.out_free   = !r_out_valid || i_out_ready;
    end

    always_comb begin
        n_id        = r_id;
        n_last      = r_last;
        n_dcnt      = r_dcnt;
        n_over      = r_over;
        n_ncnt      = r_ncnt;
        n_part      = r_part;
        n_perr      = r_perr;
        n_necnt     = r_necnt;
        n_novf      = r_novf;
        n_scan      = r_scan;
        n_rep       = r_rep;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;

        if (i_cmd.accept) begin
            if (i_in.start_graph) begin
                n_dcnt = '0;
                n_over = 1'b0;
                n_ncnt = '0;
                n_part = '0;
                n_perr = 1'b0;
            end
            n_id    = i_in.edge_id;
            n_last  = i_in.node_last;
            n_necnt = nec_base;
            n_novf  = novf_base;
            if (i_in.edge_valid) begin
                if (buf_we) begin
                    n_necnt = nec_base + NCW'(1);
                end else begin
                    n_novf = 1'b1;
                end
            end
        end
        if (i_cmd.scan_start) begin
            n_scan = '0;
        end
        if (i_cmd.scan_next) begin
            n_scan = r_scan + SCW'(1);
        end
        if (i_cmd.insert) begin
            if (ins_ok) begin
                n_dcnt = r_dcnt + SCW'(1);
            end else begin
                n_over = 1'b1;
            end
        end
        if (i_cmd.finish) begin
            n_ncnt = nc_inc;
            if (o_stat.restart) begin
                n_ncnt = 17'd1;
                n_dcnt = '0;
                n_over = 1'b0;
                n_part = part_inc;
                if (part_inc >= r_max_parts) begin
                    n_perr = 1'b1;
                end
            end
        end
        if (i_cmd.replay_start) begin
            n_rep = '0;
        end
        if (i_cmd.replay_load) begin
            n_id  = nbuf_rdata;
            n_rep = r_rep + NCW'(1);
        end
        if (i_cmd.emit) begin
            n_out.part_index = r_part;
            if (r_perr) begin
                n_out.status = sqcp_pkg::STATUS_PART_ERR;
            end else if (r_novf) begin
                n_out.status = sqcp_pkg::STATUS_NODE_OVF;
            end else begin
                n_out.status = sqcp_pkg::STATUS_OK;
            end
            n_out_valid = 1'b1;
            n_necnt     = '0;
            n_novf      = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_nodes <= sqcp_pkg::MAX_NODES_RST;
            r_max_edges <= sqcp_pkg::MAX_EDGES_RST;
            r_max_parts <= sqcp_pkg::MAX_PARTS_RST;
            r_dcnt      <= '0;
            r_over      <= 1'b0;
            r_ncnt      <= '0;
            r_part      <= '0;
            r_perr      <= 1'b0;
            r_necnt     <= '0;
            r_novf      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    sqcp_pkg::REG_MAX_NODES: r_max_nodes <= i_cfg_data;
                    sqcp_pkg::REG_MAX_EDGES: r_max_edges <= i_cfg_data[9:0];
                    sqcp_pkg::REG_MAX_PARTS: r_max_parts <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            r_dcnt      <= n_dcnt;
            r_over      <= n_over;
            r_ncnt      <= n_ncnt;
            r_part      <= n_part;
            r_perr      <= n_perr;
            r_necnt     <= n_necnt;
            r_novf      <= n_novf;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_id   <= n_id;
        r_last <= n_last;
        r_scan <= n_scan;
        r_rep  <= n_rep;
        r_out  <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// ===== src/sequential_capacity_partitioner_core.sv =====
// ----------------------------------------------------------------------------
// sequential_capacity_partitioner_core
// Greedy sequential partitioner of nodes by node count and distinct edges.
//
// Input items arrive on a valid/ready channel, one inbound edge id per
// transfer, with node_last closing a node. Each node produces one result
// transfer carrying its partition index and status on the output channel.
// Registers are written through a plain write port; the user must write them
// only while the block is idle, as the block itself does not enforce it.
// An edge item searches the edge set of the open partition one memory read
// at a time. A node end passes through the finish step; a partition restart
// also replays every buffered edge with a set search for each of them.
// The result sits in an output register; the next input is taken while it
// waits, but the next result waits until the receiver takes the first one.
// Reset clears the partition counters and restores the register defaults;
// scan/replay indices and memories are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module sequential_capacity_partitioner_core #(
    parameter int SET_DEPTH  = sqcp_pkg::SET_DEPTH_DEF,
    parameter int NODE_EDGES = sqcp_pkg::NODE_EDGES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [sqcp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [sqcp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  sqcp_pkg::t_in_item              i_in,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output sqcp_pkg::t_out_item             o_out
);

    sqcp_pkg::t_cmd  cmd;
    sqcp_pkg::t_stat stat;

    sqcp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    sqcp_dp #(.SET_DEPTH(SET_DEPTH), .NODE_EDGES(NODE_EDGES)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (i_in),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out       (o_out),
        .i_cmd       (cmd),
        .o_stat      (stat)
    );

endmodule
